/* hw/rtl/jads_pkg.sv */
// shared widths, register indexes and pipeline constants for the joystick axis scaler
// no dependencies; imported by the top level and by its checker
package jads_pkg;

    localparam int RAW_W   = 16;  // input sample
    localparam int OUT_W   = 17;  // scaled value and 17 bit registers
    localparam int PCT_W   = 7;   // deadband percent
    localparam int CFG_W   = 17;  // widest register
    localparam int IDX_W   = 3;   // register index

    localparam int TX_W    = 22;  // 25 * sample
    localparam int U_W     = 18;  // distance from the segment end
    localparam int PROD_W  = 36;  // delta * distance
    localparam int CM_W    = 25;  // bound * (100 - percent)
    localparam int NUM_W   = 41;  // full numerator
    localparam int SHIFT   = 13;  // divisor is 8192 * (100 - percent)
    localparam int A_W     = NUM_W - SHIFT;
    localparam int REM_W   = 7;   // remainder below the 7 bit divisor

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = A_W / DIV_STAGES;

    // six arithmetic stages, the divider stages and the output register
    localparam int LATENCY = 6 + DIV_STAGES + 1;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    localparam logic [IDX_W-1:0] REG_NEUTRAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PCT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_INVERT  = 3'd4;

    localparam logic signed [OUT_W-1:0] NEUTRAL_RST = 17'sd0;
    localparam logic signed [OUT_W-1:0] MIN_RST     = -17'sd32768;
    localparam logic signed [OUT_W-1:0] MAX_RST     = 17'sd32768;

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic mid;   // inside the deadband
        logic sign;  // quotient is negated
    } stage_ctl_t;

endpackage

/* hw/rtl/joystick_axis_deadband_scaler.sv */
// joystick axis deadband scaler: deadband test, piecewise linear scaling and a
// pipelined divider by (100 - percent); depends on jads_pkg
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+----------------------------
//  sample   | raw_sample                            | start & !busy, busy always low
//  result   | scaled_value                          | done strobe, one cycle
//  config   | cfg_wr_en, cfg_index, cfg_wdata       | write when cfg_wr_en high
//
// one sample may be taken every cycle; its result appears with done after the
// six arithmetic stages (multiplier, wide add, magnitude), the four radix-2
// divider stages of seven steps each and the output register
// reset clears the valid bits and loads the register reset values
// the receiver cannot stall, so nothing in the pipeline ever waits
module joystick_axis_deadband_scaler
    import jads_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [RAW_W-1:0] raw_sample,
    output logic                    done,
    output logic signed [OUT_W-1:0] scaled_value,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    // configuration
    logic signed [OUT_W-1:0] neutral_value_reg;
    logic signed [OUT_W-1:0] out_min_reg;
    logic signed [OUT_W-1:0] out_max_reg;
    logic [PCT_W-1:0]        deadband_pct_reg;
    logic                    invert_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_value_reg <= NEUTRAL_RST;
            out_min_reg       <= MIN_RST;
            out_max_reg       <= MAX_RST;
            deadband_pct_reg  <= '0;
            invert_axis_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NEUTRAL: neutral_value_reg <= $signed(cfg_wdata[OUT_W-1:0]);
                REG_MIN:     out_min_reg       <= $signed(cfg_wdata[OUT_W-1:0]);
                REG_MAX:     out_max_reg       <= $signed(cfg_wdata[OUT_W-1:0]);
                REG_PCT:     deadband_pct_reg  <= cfg_wdata[PCT_W-1:0];
                REG_INVERT:  invert_axis_reg   <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: optional negation at 17 bits
    logic                    s1_valid_reg;
    logic signed [OUT_W-1:0] s1_x_reg;
    logic signed [OUT_W-1:0] s1_x_next;

    always_comb
    begin
        s1_x_next = OUT_W'(raw_sample);
        if (invert_axis_reg)
            s1_x_next = -OUT_W'(raw_sample);
    end

    // stage 2: deadband test and segment selection
    logic                    s2_valid_reg;
    logic                    s2_mid_reg;
    logic                    s2_sign_next;
    logic signed [U_W-1:0]   s2_u_reg;
    logic signed [U_W-1:0]   s2_delta_reg;
    logic signed [OUT_W-1:0] s2_c_reg;
    logic signed [TX_W-1:0]  tx;
    logic signed [TX_W-1:0]  thr;
    logic                    below;
    logic                    above;
    logic signed [U_W-1:0]   x_ext;
    logic signed [U_W-1:0]   s2_u_next;
    logic signed [OUT_W-1:0] s2_c_next;
    logic signed [U_W-1:0]   s2_delta_next;

    assign tx    = (TX_W'(s1_x_reg) <<< 4) + (TX_W'(s1_x_reg) <<< 3) + TX_W'(s1_x_reg);
    assign thr   = $signed({2'b00, deadband_pct_reg, 13'b0});
    assign below = (tx < -thr);
    assign above = (tx > thr);
    assign x_ext = U_W'(s1_x_reg);
    assign s2_sign_next = 1'b0;

    always_comb
    begin
        if (below)
        begin
            s2_u_next = -(x_ext + 18'sd32768);
            s2_c_next = out_min_reg;
        end
        else
        begin
            s2_u_next = x_ext - 18'sd32768;
            s2_c_next = out_max_reg;
        end
        s2_delta_next = U_W'(s2_c_next) - U_W'(neutral_value_reg);
    end

    // divisor is 8192 * m with m = 100 - percent
    logic [PCT_W-1:0] div_m;
    assign div_m = PCT_FULL - deadband_pct_reg;

    // stage 3: products
    logic                     s3_valid_reg;
    logic                     s3_mid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [CM_W-1:0]   s3_cm_reg;

    // stage 4: scale by 25 and align the bound term
    logic                    s4_valid_reg;
    logic                    s4_mid_reg;
    logic signed [NUM_W-1:0] s4_p25_reg;
    logic signed [NUM_W-1:0] s4_cms_reg;
    logic signed [NUM_W-1:0] p_ext;

    assign p_ext = NUM_W'(s3_prod_reg);

    // stage 5: numerator
    logic                    s5_valid_reg;
    logic                    s5_mid_reg;
    logic signed [NUM_W-1:0] s5_num_reg;

    // stage 6: magnitude, divided by 8192
    stage_ctl_t              s6_ctl_reg;
    logic [A_W-1:0]          s6_a_reg;
    logic [NUM_W-1:0]        mag;

    assign mag = s5_num_reg[NUM_W-1] ? NUM_W'(-s5_num_reg) : NUM_W'(s5_num_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_ctl_reg       <= '0;
        end
        else
        begin
            s1_valid_reg     <= start & ~busy;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            s6_ctl_reg.valid <= s5_valid_reg;
            s6_ctl_reg.mid   <= s5_mid_reg;
            s6_ctl_reg.sign  <= s5_num_reg[NUM_W-1] ^ s2_sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg        <= s1_x_next;
        s2_mid_reg      <= ~(below | above);
        s2_u_reg        <= s2_u_next;
        s2_delta_reg    <= s2_delta_next;
        s2_c_reg        <= s2_c_next;
        s3_mid_reg      <= s2_mid_reg;
        s3_prod_reg     <= PROD_W'(s2_delta_reg) * PROD_W'(s2_u_reg);
        s3_cm_reg       <= CM_W'(s2_c_reg) * CM_W'($signed({1'b0, div_m}));
        s4_mid_reg      <= s3_mid_reg;
        s4_p25_reg      <= (p_ext <<< 4) + (p_ext <<< 3) + p_ext;
        s4_cms_reg      <= NUM_W'(s3_cm_reg) <<< SHIFT;
        s5_mid_reg      <= s4_mid_reg;
        s5_num_reg      <= s4_cms_reg + s4_p25_reg;
        s6_a_reg        <= mag[NUM_W-1:SHIFT];
    end

    // restoring divider by m: quotient bits shift in as dividend bits shift out
    stage_ctl_t       div_ctl_reg [DIV_STAGES];
    logic [A_W-1:0]   div_w_reg   [DIV_STAGES];
    logic [REM_W-1:0] div_r_reg   [DIV_STAGES];
    logic [REM_W:0]   m_ext;

    assign m_ext = {1'b0, div_m};

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        stage_ctl_t       c_in;
        logic [A_W-1:0]   w_in;
        logic [REM_W-1:0] r_in;
        logic [A_W-1:0]   w_next;
        logic [REM_W-1:0] r_next;

        if (g == 0)
        begin : g_first
            assign c_in = s6_ctl_reg;
            assign w_in = s6_a_reg;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign c_in = div_ctl_reg[g-1];
            assign w_in = div_w_reg[g-1];
            assign r_in = div_r_reg[g-1];
        end

        always_comb
        begin
            logic [REM_W:0] trial;
            w_next = w_in;
            r_next = r_in;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                trial  = {r_next, w_next[A_W-1]};
                w_next = {w_next[A_W-2:0], 1'b0};
                if (trial >= m_ext)
                begin
                    r_next    = REM_W'(trial - m_ext);
                    w_next[0] = 1'b1;
                end
                else
                begin
                    r_next = trial[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_ctl_reg[g] <= '0;
            else
                div_ctl_reg[g] <= c_in;
        end

        always_ff @(posedge clk)
        begin
            div_w_reg[g]        <= w_next;
            div_r_reg[g]        <= r_next;
        end
    end

    // output register
    stage_ctl_t              last_ctl;
    logic signed [OUT_W-1:0] quo;
    logic signed [OUT_W-1:0] scaled_next;
    logic                    done_reg;
    logic signed [OUT_W-1:0] scaled_reg;

    assign last_ctl = div_ctl_reg[DIV_STAGES-1];
    assign quo      = $signed(div_w_reg[DIV_STAGES-1][OUT_W-1:0]);

    always_comb
    begin
        if (last_ctl.mid)
            scaled_next = neutral_value_reg;
        else if (last_ctl.sign)
            scaled_next = -quo;
        else
            scaled_next = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign done         = done_reg;
    assign scaled_value = scaled_reg;

endmodule

/* hw/rtl/jads_checker.sv */
// port-level checks on the joystick axis scaler, bound to the top level
// depends on jads_pkg and joystick_axis_deadband_scaler
module jads_checker
    import jads_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [OUT_W-1:0] scaled_value
);

    // every sample is taken on the spot
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("scaler raised busy");

    // each transfer gives a result after the package latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transfer");

    a_value_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(scaled_value))
        else $error("result carries unknown bits");

endmodule

bind joystick_axis_deadband_scaler jads_checker u_jads_checker (.*);
